### sv/ihdp_pkg.sv
// ----------------------------------------------------------------------------
// ihdp_pkg
// Shared codes and types for the interval heap double-ended priority queue:
// command codes, error codes, datapath operation codes and the
// control/status structures between the controller and the datapath.
// ----------------------------------------------------------------------------
package ihdp_pkg;

   localparam int CAPACITY_DEFAULT  = 1024;
   localparam int KEY_WIDTH_DEFAULT = 32;

   localparam int FIELD_WIDTH = 32;
   localparam int COUNT_WIDTH = 11;
   localparam int RSP_DATA_WIDTH = 112;

   localparam logic [1:0] ACT_PUSH    = 2'd0;
   localparam logic [1:0] ACT_POP_MIN = 2'd1;
   localparam logic [1:0] ACT_POP_MAX = 2'd2;
   localparam logic [1:0] ACT_CLEAR   = 2'd3;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_FULL  = 2'd1;
   localparam logic [1:0] ERR_EMPTY = 2'd2;

   localparam logic [4:0] OP_NOP           = 5'd0;
   localparam logic [4:0] OP_LOAD          = 5'd1;
   localparam logic [4:0] OP_ERR_FULL      = 5'd2;
   localparam logic [4:0] OP_ERR_EMPTY     = 5'd3;
   localparam logic [4:0] OP_PUSH_INIT     = 5'd4;
   localparam logic [4:0] OP_RD_LAST       = 5'd5;
   localparam logic [4:0] OP_SMALL_POP     = 5'd6;
   localparam logic [4:0] OP_RD_ROOT       = 5'd7;
   localparam logic [4:0] OP_TAKE_ROOT     = 5'd8;
   localparam logic [4:0] OP_TAKE_LAST     = 5'd9;
   localparam logic [4:0] OP_CLEAR         = 5'd10;
   localparam logic [4:0] OP_DN_RD_A       = 5'd11;
   localparam logic [4:0] OP_DN_TAKE_A     = 5'd12;
   localparam logic [4:0] OP_DN_TAKE_B     = 5'd13;
   localparam logic [4:0] OP_DN_MOVE       = 5'd14;
   localparam logic [4:0] OP_UP_RD_PARTNER = 5'd15;
   localparam logic [4:0] OP_UP_SWAP       = 5'd16;
   localparam logic [4:0] OP_UP_RD_PMAX    = 5'd17;
   localparam logic [4:0] OP_UP_MOVE_MAX   = 5'd18;
   localparam logic [4:0] OP_UP_RD_PMIN    = 5'd19;
   localparam logic [4:0] OP_UP_MOVE_MIN   = 5'd20;
   localparam logic [4:0] OP_WRITE_KEY     = 5'd21;
   localparam logic [4:0] OP_RD_ZERO       = 5'd22;
   localparam logic [4:0] OP_TAKE_MAX      = 5'd23;
   localparam logic [4:0] OP_TAKE_MIN      = 5'd24;
   localparam logic [4:0] OP_TAKE_BOTH     = 5'd25;
   localparam logic [4:0] OP_ZERO_MINMAX   = 5'd26;

   typedef struct packed {
      logic [4:0] op;
      logic       publish;
   } cmd_type;

   typedef struct packed {
      logic [1:0] act;
      logic       cnt_zero;
      logic       cnt_full;
      logic       cnt_ge2;
      logic       small_pop;
      logic       k_gt1;
      logic       a_ok;
      logic       b_ok;
      logic       partner_ok;
      logic       dn_go;
      logic       pair_swap;
      logic       max_go;
      logic       min_go;
   } status_type;

endpackage

### sv/ihdp_datapath.sv
// ----------------------------------------------------------------------------
// ihdp_datapath
// Heap store, index and key registers, comparators and result registers.
// Executes one operation code per cycle from the controller.
// ----------------------------------------------------------------------------
module ihdp_datapath #(
   parameter int CAPACITY  = ihdp_pkg::CAPACITY_DEFAULT,
   parameter int KEY_WIDTH = ihdp_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ihdp_pkg::cmd_type                   cmd,
   input  logic [1:0]                          req_action,
   input  logic [ihdp_pkg::FIELD_WIDTH-1:0]    req_value,
   output ihdp_pkg::status_type                st,
   output logic [ihdp_pkg::RSP_DATA_WIDTH-1:0] rsp_data,
   output logic [1:0]                          rsp_error
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int XW    = CNT_W + 2;

   logic [KEY_WIDTH-1:0] mem [CAPACITY];

   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [IDX_W-1:0]     k_ff, k_in;
   logic [IDX_W-1:0]     c_ff, c_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [KEY_WIDTH-1:0] vc_ff, vc_in;
   logic [KEY_WIDTH-1:0] rem_ff, rem_in;
   logic [KEY_WIDTH-1:0] min_ff, min_in;
   logic [KEY_WIDTH-1:0] max_ff, max_in;
   logic [KEY_WIDTH-1:0] rd_ff;
   logic [1:0]           act_ff, act_in;
   logic [1:0]           err_ff, err_in;

   logic [ihdp_pkg::FIELD_WIDTH-1:0] o_rem_ff, o_min_ff, o_max_ff;
   logic [ihdp_pkg::COUNT_WIDTH-1:0] o_cnt_ff;
   logic [1:0]                       o_err_ff;

   logic [IDX_W-1:0] rd_addr, wr_addr, root, partner, pmax, pmin, last;
   logic [KEY_WIDTH-1:0] wr_data;
   logic             wr_en;
   logic [XW-1:0]    a_x, b_x, cnt_x;
   logic             k_odd;

   assign k_odd   = k_ff[0];
   assign cnt_x   = XW'(cnt_ff);
   assign a_x     = XW'({k_ff, 1'b0}) + (k_odd ? XW'(1) : XW'(2));
   assign b_x     = a_x + XW'(2);
   assign root    = (act_ff == ihdp_pkg::ACT_POP_MIN) ? IDX_W'(1) : IDX_W'(0);
   assign partner = k_ff ^ IDX_W'(1);
   assign last    = IDX_W'(cnt_ff - CNT_W'(1));
   assign pmax    = ((k_ff >> 1) - IDX_W'(1)) & ~IDX_W'(1);
   assign pmin    = pmax | IDX_W'(1);

   always_comb begin
      st.act        = act_ff;
      st.cnt_zero   = (cnt_ff == '0);
      st.cnt_full   = (cnt_x >= XW'(CAPACITY));
      st.cnt_ge2    = (cnt_x >= XW'(2));
      st.small_pop  = ((act_ff == ihdp_pkg::ACT_POP_MIN) && (cnt_x <= XW'(2))) ||
                      ((act_ff == ihdp_pkg::ACT_POP_MAX) && (cnt_x == XW'(1)));
      st.k_gt1      = (k_ff > IDX_W'(1));
      st.a_ok       = (a_x < cnt_x);
      st.b_ok       = (b_x < cnt_x);
      st.partner_ok = (XW'(partner) < cnt_x);
      st.dn_go      = k_odd ? (vc_ff < key_ff) : (key_ff < vc_ff);
      st.pair_swap  = k_odd ? (rd_ff < key_ff) : (key_ff < rd_ff);
      st.max_go     = (rd_ff < key_ff);
      st.min_go     = (key_ff < rd_ff);
   end

   always_comb begin
      cnt_in  = cnt_ff;
      k_in    = k_ff;
      c_in    = c_ff;
      key_in  = key_ff;
      vc_in   = vc_ff;
      rem_in  = rem_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      act_in  = act_ff;
      err_in  = err_ff;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = k_ff;
      wr_data = rd_ff;
      case (cmd.op)
         ihdp_pkg::OP_LOAD: begin
            act_in = req_action;
            key_in = KEY_WIDTH'(req_value);
            err_in = ihdp_pkg::ERR_NONE;
            rem_in = '0;
         end
         ihdp_pkg::OP_ERR_FULL:  err_in = ihdp_pkg::ERR_FULL;
         ihdp_pkg::OP_ERR_EMPTY: err_in = ihdp_pkg::ERR_EMPTY;
         ihdp_pkg::OP_PUSH_INIT: begin
            k_in   = IDX_W'(cnt_ff);
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ihdp_pkg::OP_RD_LAST: rd_addr = last;
         ihdp_pkg::OP_SMALL_POP: begin
            rem_in = rd_ff;
            cnt_in = cnt_ff - CNT_W'(1);
         end
         ihdp_pkg::OP_RD_ROOT: rd_addr = root;
         ihdp_pkg::OP_TAKE_ROOT: begin
            rem_in  = rd_ff;
            rd_addr = last;
         end
         ihdp_pkg::OP_TAKE_LAST: begin
            key_in = rd_ff;
            cnt_in = cnt_ff - CNT_W'(1);
            k_in   = root;
         end
         ihdp_pkg::OP_CLEAR: cnt_in = '0;
         ihdp_pkg::OP_DN_RD_A: rd_addr = IDX_W'(a_x);
         ihdp_pkg::OP_DN_TAKE_A: begin
            c_in    = IDX_W'(a_x);
            vc_in   = rd_ff;
            rd_addr = IDX_W'(b_x);
         end
         ihdp_pkg::OP_DN_TAKE_B: begin
            if (k_odd ? !(vc_ff < rd_ff) : !(rd_ff < vc_ff)) begin
               c_in  = IDX_W'(b_x);
               vc_in = rd_ff;
            end
         end
         ihdp_pkg::OP_DN_MOVE: begin
            wr_en   = 1'b1;
            wr_data = vc_ff;
            k_in    = c_ff;
         end
         ihdp_pkg::OP_UP_RD_PARTNER: rd_addr = partner;
         ihdp_pkg::OP_UP_SWAP: begin
            wr_en = 1'b1;
            k_in  = partner;
         end
         ihdp_pkg::OP_UP_RD_PMAX: rd_addr = pmax;
         ihdp_pkg::OP_UP_MOVE_MAX: begin
            wr_en = 1'b1;
            k_in  = pmax;
         end
         ihdp_pkg::OP_UP_RD_PMIN: rd_addr = pmin;
         ihdp_pkg::OP_UP_MOVE_MIN: begin
            wr_en = 1'b1;
            k_in  = pmin;
         end
         ihdp_pkg::OP_WRITE_KEY: begin
            wr_en   = 1'b1;
            wr_data = key_ff;
         end
         ihdp_pkg::OP_RD_ZERO: rd_addr = '0;
         ihdp_pkg::OP_TAKE_MAX: begin
            max_in  = rd_ff;
            rd_addr = IDX_W'(1);
         end
         ihdp_pkg::OP_TAKE_MIN: min_in = rd_ff;
         ihdp_pkg::OP_TAKE_BOTH: begin
            min_in = rd_ff;
            max_in = rd_ff;
         end
         ihdp_pkg::OP_ZERO_MINMAX: begin
            min_in = '0;
            max_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      k_ff   <= k_in;
      c_ff   <= c_in;
      key_ff <= key_in;
      vc_ff  <= vc_in;
      rem_ff <= rem_in;
      min_ff <= min_in;
      max_ff <= max_in;
      act_ff <= act_in;
      err_ff <= err_in;
      if (cmd.publish) begin
         o_rem_ff <= ihdp_pkg::FIELD_WIDTH'(64'(rem_ff));
         o_min_ff <= ihdp_pkg::FIELD_WIDTH'(64'(min_ff));
         o_max_ff <= ihdp_pkg::FIELD_WIDTH'(64'(max_ff));
         o_cnt_ff <= ihdp_pkg::COUNT_WIDTH'(cnt_ff);
         o_err_ff <= err_ff;
      end
   end

   assign rsp_data  = {5'd0, o_cnt_ff, o_max_ff, o_min_ff, o_rem_ff};
   assign rsp_error = o_err_ff;

endmodule

### sv/ihdp_control.sv
// ----------------------------------------------------------------------------
// ihdp_control
// Sequencer for one queue command: decode, sift down, sift up, read back the
// extremes, then hand the result to the output register.
// ----------------------------------------------------------------------------
module ihdp_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  ihdp_pkg::status_type st,
   output ihdp_pkg::cmd_type    cmd
);

   localparam logic [4:0] S_IDLE        = 5'd0;
   localparam logic [4:0] S_DECODE      = 5'd1;
   localparam logic [4:0] S_SMALL       = 5'd2;
   localparam logic [4:0] S_ROOT        = 5'd3;
   localparam logic [4:0] S_LAST        = 5'd4;
   localparam logic [4:0] S_DN_A        = 5'd5;
   localparam logic [4:0] S_DN_B        = 5'd6;
   localparam logic [4:0] S_DN_C        = 5'd7;
   localparam logic [4:0] S_DN_CMP      = 5'd8;
   localparam logic [4:0] S_UP_PAIR     = 5'd9;
   localparam logic [4:0] S_UP_PAIR_CMP = 5'd10;
   localparam logic [4:0] S_UPMX        = 5'd11;
   localparam logic [4:0] S_UPMX_CMP    = 5'd12;
   localparam logic [4:0] S_UPMN        = 5'd13;
   localparam logic [4:0] S_UPMN_CMP    = 5'd14;
   localparam logic [4:0] S_WRK         = 5'd15;
   localparam logic [4:0] S_FIN         = 5'd16;
   localparam logic [4:0] S_FIN_MAX     = 5'd17;
   localparam logic [4:0] S_FIN_MIN     = 5'd18;
   localparam logic [4:0] S_DONE        = 5'd19;

   logic [4:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.op      = ihdp_pkg::OP_NOP;
      cmd.publish = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = ihdp_pkg::OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (st.act)
               ihdp_pkg::ACT_PUSH: begin
                  if (st.cnt_full) begin
                     cmd.op   = ihdp_pkg::OP_ERR_FULL;
                     state_in = S_FIN;
                  end else begin
                     cmd.op   = ihdp_pkg::OP_PUSH_INIT;
                     state_in = S_UP_PAIR;
                  end
               end
               ihdp_pkg::ACT_POP_MIN, ihdp_pkg::ACT_POP_MAX: begin
                  if (st.cnt_zero) begin
                     cmd.op   = ihdp_pkg::OP_ERR_EMPTY;
                     state_in = S_FIN;
                  end else if (st.small_pop) begin
                     cmd.op   = ihdp_pkg::OP_RD_LAST;
                     state_in = S_SMALL;
                  end else begin
                     cmd.op   = ihdp_pkg::OP_RD_ROOT;
                     state_in = S_ROOT;
                  end
               end
               default: begin
                  cmd.op   = ihdp_pkg::OP_CLEAR;
                  state_in = S_FIN;
               end
            endcase
         end
         S_SMALL: begin
            cmd.op   = ihdp_pkg::OP_SMALL_POP;
            state_in = S_FIN;
         end
         S_ROOT: begin
            cmd.op   = ihdp_pkg::OP_TAKE_ROOT;
            state_in = S_LAST;
         end
         S_LAST: begin
            cmd.op   = ihdp_pkg::OP_TAKE_LAST;
            state_in = S_DN_A;
         end
         S_DN_A: begin
            if (st.a_ok) begin
               cmd.op   = ihdp_pkg::OP_DN_RD_A;
               state_in = S_DN_B;
            end else begin
               state_in = S_UP_PAIR;
            end
         end
         S_DN_B: begin
            cmd.op   = ihdp_pkg::OP_DN_TAKE_A;
            state_in = st.b_ok ? S_DN_C : S_DN_CMP;
         end
         S_DN_C: begin
            cmd.op   = ihdp_pkg::OP_DN_TAKE_B;
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (st.dn_go) begin
               cmd.op   = ihdp_pkg::OP_DN_MOVE;
               state_in = S_DN_A;
            end else begin
               state_in = S_UP_PAIR;
            end
         end
         S_UP_PAIR: begin
            if (st.partner_ok) begin
               cmd.op   = ihdp_pkg::OP_UP_RD_PARTNER;
               state_in = S_UP_PAIR_CMP;
            end else begin
               state_in = S_UPMX;
            end
         end
         S_UP_PAIR_CMP: begin
            if (st.pair_swap) begin
               cmd.op = ihdp_pkg::OP_UP_SWAP;
            end
            state_in = S_UPMX;
         end
         S_UPMX: begin
            if (st.k_gt1) begin
               cmd.op   = ihdp_pkg::OP_UP_RD_PMAX;
               state_in = S_UPMX_CMP;
            end else begin
               state_in = S_UPMN;
            end
         end
         S_UPMX_CMP: begin
            if (st.max_go) begin
               cmd.op   = ihdp_pkg::OP_UP_MOVE_MAX;
               state_in = S_UPMX;
            end else begin
               state_in = S_UPMN;
            end
         end
         S_UPMN: begin
            if (st.k_gt1) begin
               cmd.op   = ihdp_pkg::OP_UP_RD_PMIN;
               state_in = S_UPMN_CMP;
            end else begin
               state_in = S_WRK;
            end
         end
         S_UPMN_CMP: begin
            if (st.min_go) begin
               cmd.op   = ihdp_pkg::OP_UP_MOVE_MIN;
               state_in = S_UPMN;
            end else begin
               state_in = S_WRK;
            end
         end
         S_WRK: begin
            cmd.op   = ihdp_pkg::OP_WRITE_KEY;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (st.cnt_zero) begin
               cmd.op   = ihdp_pkg::OP_ZERO_MINMAX;
               state_in = S_DONE;
            end else begin
               cmd.op   = ihdp_pkg::OP_RD_ZERO;
               state_in = S_FIN_MAX;
            end
         end
         S_FIN_MAX: begin
            if (st.cnt_ge2) begin
               cmd.op   = ihdp_pkg::OP_TAKE_MAX;
               state_in = S_FIN_MIN;
            end else begin
               cmd.op   = ihdp_pkg::OP_TAKE_BOTH;
               state_in = S_DONE;
            end
         end
         S_FIN_MIN: begin
            cmd.op   = ihdp_pkg::OP_TAKE_MIN;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!valid_ff || rsp_tready) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign valid_in = cmd.publish | (valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

### sv/interval_heap_double_ended_pq.sv
// ----------------------------------------------------------------------------
// interval_heap_double_ended_pq
// Double-ended priority queue of unsigned keys kept as an interval heap.
//
// The request channel carries one command per transaction: the action code on
// req_tuser (push, pop minimum, pop maximum, clear) and the key on req_tdata.
// The response channel returns one transaction per command with the removed
// key, the current minimum and maximum, the count and, on rsp_tuser, an error
// code. A push when full or a pop when empty leaves the store unchanged.
// Commands run one at a time. A push sifts the new key up; a larger pop moves
// the last key to the emptied root and sifts it down, then up, while a small
// pop, a clear or a failed command needs no sift. The heap store is read once
// per cycle with registered data, and the sift depth sets a command's length.
// A finished response sits in an output register, so the next command is
// accepted while it waits; if the receiver stalls, a second result waits in
// the sequencer until the register is free.
// Reset empties the queue at once and drops any pending response; the store
// contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module interval_heap_double_ended_pq #(
   parameter int CAPACITY  = ihdp_pkg::CAPACITY_DEFAULT,
   parameter int KEY_WIDTH = ihdp_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // value [31:0]
   input  logic [ihdp_pkg::FIELD_WIDTH-1:0]    req_tdata,
   // action [1:0]
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // removed_value [31:0], min_value [63:32], max_value [95:64], count [106:96]
   output logic [ihdp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // error [1:0]
   output logic [1:0]                          rsp_tuser
);

   ihdp_pkg::cmd_type    cmd;
   ihdp_pkg::status_type st;

   ihdp_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .st         (st),
      .cmd        (cmd)
   );

   ihdp_datapath #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_action (req_tuser),
      .req_value  (req_tdata),
      .st         (st),
      .rsp_data   (rsp_tdata),
      .rsp_error  (rsp_tuser)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("Request accepted while a command was in progress.");

   a_empty_extremes: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[106:96] == '0) |->
      (rsp_tdata[63:32] == '0 && rsp_tdata[95:64] == '0))
      else $error("Empty queue reported a nonzero minimum or maximum.");

   a_error_no_removal: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ihdp_pkg::ERR_NONE) |-> rsp_tdata[31:0] == '0)
      else $error("Failed command reported a removed key.");

endmodule

### bench/tb_interval_heap_double_ended_pq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_heap_double_ended_pq
// Self-checking bench for the interval heap double-ended priority queue.
// A behavioral interval heap predicts every response; directed tests cover
// the empty, single-key and clear cases, a random command stream with random
// gaps and response stalls follows; a full-queue test drives deep sift paths.
// ----------------------------------------------------------------------------
module tb_interval_heap_double_ended_pq;

   localparam int CAP = 1024;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [31:0] removed;
      logic [31:0] min_key;
      logic [31:0] max_key;
      logic [10:0] count;
      logic [1:0]  err;
   } pq_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0] req_tuser = ihdp_pkg::ACT_PUSH;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [ihdp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   logic [31:0] model_keys [CAP];
   int unsigned model_count = 0;
   pq_result_type expected_results [$];
   int errors = 0;
   int cycles = 0;
   logic stall_enable = 1'b1;

   interval_heap_double_ended_pq u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic void swap_keys(int unsigned a, int unsigned b);
      logic [31:0] t;
      t = model_keys[a];
      model_keys[a] = model_keys[b];
      model_keys[b] = t;
   endfunction

   function automatic int unsigned heap_sift_down(int unsigned k);
      int unsigned a, b, c;
      forever begin
         if (k[0]) begin
            a = 2 * k + 1;
            b = 2 * k + 3;
            if (a >= model_count) break;
            c = (b >= model_count || model_keys[a] < model_keys[b]) ? a : b;
            if (!(model_keys[c] < model_keys[k])) break;
         end else begin
            a = 2 * k + 2;
            b = 2 * k + 4;
            if (a >= model_count) break;
            c = (b >= model_count || model_keys[b] < model_keys[a]) ? a : b;
            if (!(model_keys[k] < model_keys[c])) break;
         end
         swap_keys(k, c);
         k = c;
      end
      return k;
   endfunction

   function automatic void heap_sift_up(int unsigned k);
      int unsigned p;
      if ((k | 1) < model_count && model_keys[k & ~1] < model_keys[k | 1]) begin
         swap_keys(k & ~1, k | 1);
         k = k ^ 1;
      end
      while (k > 1) begin
         p = (((k >> 1) - 1) & ~1);
         if (!(model_keys[p] < model_keys[k])) break;
         swap_keys(k, p);
         k = p;
      end
      while (k > 1) begin
         p = (((k >> 1) - 1) & ~1) | 1;
         if (!(model_keys[k] < model_keys[p])) break;
         swap_keys(k, p);
         k = p;
      end
   endfunction

   function automatic pq_result_type apply_command(logic [1:0] act, logic [31:0] key);
      pq_result_type r;
      r = '0;
      case (act)
         ihdp_pkg::ACT_PUSH: begin
            if (model_count >= CAP) begin
               r.err = ihdp_pkg::ERR_FULL;
            end else begin
               model_keys[model_count] = key;
               model_count++;
               heap_sift_up(model_count - 1);
            end
         end
         ihdp_pkg::ACT_POP_MIN: begin
            if (model_count == 0) begin
               r.err = ihdp_pkg::ERR_EMPTY;
            end else if (model_count <= 2) begin
               r.removed = model_keys[model_count - 1];
               model_count--;
            end else begin
               r.removed = model_keys[1];
               swap_keys(1, model_count - 1);
               model_count--;
               heap_sift_up(heap_sift_down(1));
            end
         end
         ihdp_pkg::ACT_POP_MAX: begin
            if (model_count == 0) begin
               r.err = ihdp_pkg::ERR_EMPTY;
            end else if (model_count == 1) begin
               r.removed = model_keys[0];
               model_count = 0;
            end else begin
               r.removed = model_keys[0];
               swap_keys(0, model_count - 1);
               model_count--;
               heap_sift_up(heap_sift_down(0));
            end
         end
         default: model_count = 0;
      endcase
      if (model_count != 0) begin
         r.min_key = model_keys[model_count >= 2 ? 1 : 0];
         r.max_key = model_keys[0];
      end
      r.count = model_count[10:0];
      return r;
   endfunction

   task automatic send_command(logic [1:0] act, logic [31:0] key);
      int unsigned gap;
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= key;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.insert(expected_results.size(), apply_command(act, key));
   endtask

   always @(posedge clock) begin
      pq_result_type got, want;
      if (rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                rsp_tdata[106:96], rsp_tuser};
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (got.removed !== want.removed)
               $display("%0t: removed exp %h got %h", $time, want.removed, got.removed);
            if (got.min_key !== want.min_key)
               $display("%0t: min exp %h got %h", $time, want.min_key, got.min_key);
            if (got.max_key !== want.max_key)
               $display("%0t: max exp %h got %h", $time, want.max_key, got.max_key);
            if (got.count !== want.count)
               $display("%0t: count exp %0d got %0d", $time, want.count, got.count);
            if (got.err !== want.err)
               $display("%0t: error exp %0d got %0d", $time, want.err, got.err);
            if (got !== want) errors++;
         end
      end
   end

   int unsigned stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (!stall_enable) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         stall_left <= $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic test_empty_and_single();
      send_command(ihdp_pkg::ACT_POP_MIN, 32'hFFFF_FFFF);
      send_command(ihdp_pkg::ACT_POP_MAX, 32'h0);
      send_command(ihdp_pkg::ACT_PUSH, 32'hFFFF_FFFF);
      send_command(ihdp_pkg::ACT_POP_MIN, 32'h0);
      send_command(ihdp_pkg::ACT_PUSH, 32'h0);
      send_command(ihdp_pkg::ACT_POP_MAX, 32'h0);
      send_command(ihdp_pkg::ACT_PUSH, 32'h0);
      send_command(ihdp_pkg::ACT_PUSH, 32'hFFFF_FFFF);
      send_command(ihdp_pkg::ACT_PUSH, 32'h5555_AAAA);
      send_command(ihdp_pkg::ACT_PUSH, 32'hAAAA_5555);
      send_command(ihdp_pkg::ACT_POP_MAX, 32'h0);
      send_command(ihdp_pkg::ACT_POP_MIN, 32'h0);
      send_command(ihdp_pkg::ACT_CLEAR, 32'h1234_5678);
      send_command(ihdp_pkg::ACT_POP_MAX, 32'h0);
   endtask

   task automatic test_full();
      repeat (CAP + 2) send_command(ihdp_pkg::ACT_PUSH, $urandom_range(0, 3) == 0 ?
                                    $urandom_range(0, 15) : $urandom);
      repeat (40) send_command($urandom_range(0, 1) ? ihdp_pkg::ACT_POP_MIN :
                               ihdp_pkg::ACT_POP_MAX, '0);
      send_command(ihdp_pkg::ACT_CLEAR, '0);
   endtask

   task automatic test_random_mix(int n);
      logic [1:0] act;
      logic [31:0] key;
      stall_enable = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) stall_enable = 1'b1;
         case ($urandom_range(0, 19))
            0: act = ihdp_pkg::ACT_CLEAR;
            1, 2, 3, 4, 5, 6, 7, 8, 9: act = ihdp_pkg::ACT_PUSH;
            10, 11, 12, 13, 14: act = ihdp_pkg::ACT_POP_MIN;
            default: act = ihdp_pkg::ACT_POP_MAX;
         endcase
         key = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 31);
         send_command(act, key);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_single();
      test_random_mix(60);
      test_full();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### sim.f
sv/ihdp_pkg.sv
sv/ihdp_datapath.sv
sv/ihdp_control.sv
sv/interval_heap_double_ended_pq.sv
bench/tb_interval_heap_double_ended_pq.sv
